// ===== hdl/bir_pkg.sv =====
// ----------------------------------------------------------------------------
// bir_pkg
// Shared widths, register indexes, command codes and bus types for the
// bilinear image resize pipeline.
// ----------------------------------------------------------------------------
package bir_pkg;

    // Field widths of the stream words
    localparam int SAMPLE_W  = 16;
    localparam int PLANE_W   = 2;
    localparam int COORD_W   = 10;
    localparam int DATA_W    = 40;

    // Register widths
    localparam int SIZE_W    = 7;
    localparam int COUNT_W   = 3;
    localparam int STEP_W    = 22;

    // Source position arithmetic, Q6.16 step times a 10-bit coordinate
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = COORD_W + STEP_W;
    localparam int IP_W      = POS_W - FRAC_BITS;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [CFG_ADDR_W-1:0] REG_IN_WIDTH      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_HEIGHT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COL_STEP      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_STEP      = 3'd4;

    // Register values after reset
    localparam logic [SIZE_W-1:0]  RST_IN_WIDTH      = 7'd64;
    localparam logic [SIZE_W-1:0]  RST_IN_HEIGHT     = 7'd64;
    localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;
    localparam logic [STEP_W-1:0]  RST_COL_STEP      = 22'd65536;
    localparam logic [STEP_W-1:0]  RST_ROW_STEP      = 22'd65536;

    // Command codes carried in tuser of the input word
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RESIZE = 1'b1;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_MAX_PLANES  = 4;
    localparam int DEF_WEIGHT_BITS = 8;

    // Floor and ceiling neighbor indexes along one axis
    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } t_span;

    // Item bookkeeping that travels with the valid bits; flag is the range
    // error for a resize and the in-store check for a load
    typedef struct packed {
        logic               cmd;
        logic [PLANE_W-1:0] plane;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               flag;
    } t_item;

    // Sample write into the image store
    typedef struct packed {
        logic                we;
        logic [PLANE_W-1:0]  plane;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [SAMPLE_W-1:0] sample;
    } t_wr;

    // Four corner samples: [0] top left, [1] top right, [2] bottom left,
    // [3] bottom right
    typedef logic [3:0][SAMPLE_W-1:0] t_quad;

endpackage

// ===== hdl/bir_axis.sv =====
// ----------------------------------------------------------------------------
// bir_axis
// Source position along one axis: coordinate times step, then the clamped
// floor and ceiling indexes and the blend weight. Two register stages.
// ----------------------------------------------------------------------------
module bir_axis #(
    parameter int MAX_SIZE    = bir_pkg::DEF_MAX_WIDTH,
    parameter int WEIGHT_BITS = bir_pkg::DEF_WEIGHT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [bir_pkg::COORD_W-1:0]  i_coord,
    input  logic [bir_pkg::STEP_W-1:0]   i_step,
    input  logic [bir_pkg::SIZE_W-1:0]   i_size,
    output bir_pkg::t_span               o_span,
    output logic [WEIGHT_BITS-1:0]       o_weight
);
    import bir_pkg::*;

    localparam logic [COORD_W-1:0] TOP_MAX = COORD_W'(MAX_SIZE - 1);

    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    t_span                  r_span;
    t_span                  n_span;
    logic [WEIGHT_BITS-1:0] r_weight;
    logic [WEIGHT_BITS-1:0] n_weight;

    logic [IP_W-1:0]        w_ip;
    logic [FRAC_BITS-1:0]   w_fr;
    logic [IP_W:0]          w_ceil;
    logic [COORD_W-1:0]     w_top;

    // Scale the coordinate into the source grid
    assign n_pos = POS_W'(i_coord) * POS_W'(i_step);

    // Last valid index; a zero size acts as one, an oversize as the maximum
    always_comb begin
        if (i_size == '0) begin
            w_top = '0;
        end else if ((COORD_W+1)'(i_size) > (COORD_W+1)'(MAX_SIZE)) begin
            w_top = TOP_MAX;
        end else begin
            w_top = COORD_W'(i_size - SIZE_W'(1));
        end
    end

    // Split into integer and fraction, saturate both neighbors at the edge
    always_comb begin
        w_ip   = r_pos[POS_W-1:FRAC_BITS];
        w_fr   = r_pos[FRAC_BITS-1:0];
        w_ceil = (IP_W+1)'(w_ip) + (IP_W+1)'(w_fr != '0);
        n_span.lo = (w_ip > IP_W'(w_top)) ? w_top : w_ip[COORD_W-1:0];
        n_span.hi = (w_ceil > (IP_W+1)'(w_top)) ? w_top : w_ceil[COORD_W-1:0];
        n_weight  = w_fr[FRAC_BITS-1 -: WEIGHT_BITS];
    end

    // Advance both stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos    <= n_pos;
            r_span   <= n_span;
            r_weight <= n_weight;
        end
    end

    assign o_span   = r_span;
    assign o_weight = r_weight;

endmodule

// ===== hdl/bir_store.sv =====
// ----------------------------------------------------------------------------
// bir_store
// Image store split into four banks by row and column parity, so the four
// neighbors of a position always fall into distinct banks (or coincide).
// One write and one read per bank per cycle while enabled, read data registered.
// ----------------------------------------------------------------------------
module bir_store #(
    parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PLANES = bir_pkg::DEF_MAX_PLANES
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  bir_pkg::t_wr                 i_wr,
    input  logic [bir_pkg::PLANE_W-1:0]  i_plane,
    input  bir_pkg::t_span               i_yspan,
    input  bir_pkg::t_span               i_xspan,
    output bir_pkg::t_quad               o_quad
);
    import bir_pkg::*;

    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
    localparam int DEPTH  = MAX_PLANES * HALF_H * HALF_W;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SAMPLE_W-1:0] r_rd [4];
    logic                r_yl0;
    logic                r_yh0;
    logic                r_xl0;
    logic                r_xh0;

    // Bank address of a sample: plane, then half row, then half column
    function automatic logic [AW-1:0] f_addr(
        input logic [PLANE_W-1:0] p,
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c
    );
        return AW'(32'(p) * (HALF_H * HALF_W) + 32'(r[COORD_W-1:1]) * HALF_W
                   + 32'(c[COORD_W-1:1]));
    endfunction

    // Choose the bank word by row and column parity
    function automatic logic [SAMPLE_W-1:0] f_pick(
        input logic                rp,
        input logic                cp,
        input logic [SAMPLE_W-1:0] d0,
        input logic [SAMPLE_W-1:0] d1,
        input logic [SAMPLE_W-1:0] d2,
        input logic [SAMPLE_W-1:0] d3
    );
        logic [SAMPLE_W-1:0] res;
        case ({rp, cp})
            2'b00:   res = d0;
            2'b01:   res = d1;
            2'b10:   res = d2;
            default: res = d3;
        endcase
        return res;
    endfunction

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic RP = 1'((b >> 1) & 1);
        localparam logic CP = 1'(b & 1);

        logic [SAMPLE_W-1:0] r_mem [DEPTH];
        logic [COORD_W-1:0]  w_row;
        logic [COORD_W-1:0]  w_col;
        logic [AW-1:0]       w_raddr;
        logic [AW-1:0]       w_waddr;
        logic                w_we;

        // Each bank serves whichever neighbor row and column has its parity
        assign w_row   = (i_yspan.lo[0] == RP) ? i_yspan.lo : i_yspan.hi;
        assign w_col   = (i_xspan.lo[0] == CP) ? i_xspan.lo : i_xspan.hi;
        assign w_raddr = f_addr(i_plane, w_row, w_col);
        assign w_waddr = f_addr(i_wr.plane, i_wr.row, i_wr.col);
        assign w_we    = i_en && i_wr.we && (i_wr.row[0] == RP) && (i_wr.col[0] == CP);

        // Write a load word, read for a resize word
        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_waddr] <= i_wr.sample;
            end
            if (i_en) begin
                r_rd[b] <= r_mem[w_raddr];
            end
        end
    end

    // Hold the parities to route bank words to corners
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yl0 <= i_yspan.lo[0];
            r_yh0 <= i_yspan.hi[0];
            r_xl0 <= i_xspan.lo[0];
            r_xh0 <= i_xspan.hi[0];
        end
    end

    always_comb begin
        o_quad[0] = f_pick(r_yl0, r_xl0, r_rd[0], r_rd[1], r_rd[2], r_rd[3]);
        o_quad[1] = f_pick(r_yl0, r_xh0, r_rd[0], r_rd[1], r_rd[2], r_rd[3]);
        o_quad[2] = f_pick(r_yh0, r_xl0, r_rd[0], r_rd[1], r_rd[2], r_rd[3]);
        o_quad[3] = f_pick(r_yh0, r_xh0, r_rd[0], r_rd[1], r_rd[2], r_rd[3]);
    end

endmodule

// ===== hdl/bir_blend.sv =====
// ----------------------------------------------------------------------------
// bir_blend
// Weighted sum of the four corners: weight products, sample products,
// pair sums, then the final add with round to nearest (half up).
// ----------------------------------------------------------------------------
module bir_blend #(
    parameter int WEIGHT_BITS = bir_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [WEIGHT_BITS-1:0]        i_wx,
    input  logic [WEIGHT_BITS-1:0]        i_wy,
    input  bir_pkg::t_quad                i_quad,
    output logic [bir_pkg::SAMPLE_W-1:0]  o_pixel
);
    import bir_pkg::*;

    localparam int WB1 = WEIGHT_BITS + 1;
    localparam int WP  = 2 * WEIGHT_BITS + 1;
    localparam int PW  = WP + SAMPLE_W + 1;
    localparam int SW  = PW + 2;
    localparam logic [WB1-1:0]       ONE  = WB1'(1) << WEIGHT_BITS;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (2 * WEIGHT_BITS - 1);

    logic [WB1-1:0]          w_owx;
    logic [WB1-1:0]          w_owy;
    logic [WB1-1:0]          w_wx;
    logic [WB1-1:0]          w_wy;
    logic [WP-1:0]           n_wp [4];
    logic [WP-1:0]           r_wp [4];
    logic signed [PW-1:0]    n_prod [4];
    logic signed [PW-1:0]    r_prod [4];
    logic signed [PW:0]      r_s01;
    logic signed [PW:0]      r_s23;
    logic signed [SW-1:0]    w_total;

    // Corner weights as products of the axis weights
    always_comb begin
        w_wx    = WB1'(i_wx);
        w_wy    = WB1'(i_wy);
        w_owx   = ONE - w_wx;
        w_owy   = ONE - w_wy;
        n_wp[0] = WP'(w_owx) * WP'(w_owy);
        n_wp[1] = WP'(w_wx)  * WP'(w_owy);
        n_wp[2] = WP'(w_owx) * WP'(w_wy);
        n_wp[3] = WP'(w_wx)  * WP'(w_wy);
    end

    // Scale each corner sample
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_prod[k] = PW'($signed(i_quad[k])) * PW'($signed({1'b0, r_wp[k]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_wp[k]   <= n_wp[k];
                r_prod[k] <= n_prod[k];
            end
            r_s01 <= (PW+1)'(r_prod[0]) + (PW+1)'(r_prod[1]);
            r_s23 <= (PW+1)'(r_prod[2]) + (PW+1)'(r_prod[3]);
        end
    end

    // Round to nearest and drop the weight scale
    assign w_total = SW'(r_s01) + SW'(r_s23) + HALF;
    assign o_pixel = w_total[2*WEIGHT_BITS +: SAMPLE_W];

endmodule

// ===== hdl/bilinear_image_resize.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Bilinear resize with aligned corners over a banked planar image store.
// Load words fill the store, resize words produce one interpolated pixel.
// ----------------------------------------------------------------------------
//  channel   ports                  word contents (low bit first)
//  --------  ---------------------  ----------------------------------------
//  s_axis    tvalid/tready/tdata    plane[1:0] row[11:2] col[21:12]
//            tuser                  sample[37:22]; tuser = cmd
//  m_axis    tvalid/tready/tdata    pixel[15:0] plane[17:16] row[27:18]
//            tuser                  col[37:28]; tuser = range_error
//  cfg       i_cfg_we/addr/wdata    register index, value (write only)
//
//  One word per cycle in and out unless m_axis stalls. A resize result
//  passes two stages of position math, one store read, two stages of
//  multiply and add, then the output register on its way to m_axis.
//  Reset loads the configuration defaults and clears the valid bits; the
//  image store keeps its contents and is undefined until loaded.
//  A stalled m_axis parks one result in a skid register; s_axis tready drops
//  only when both the output and skid registers are full.
// ----------------------------------------------------------------------------
module bilinear_image_resize #(
    parameter int MAX_WIDTH   = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PLANES  = bir_pkg::DEF_MAX_PLANES,
    parameter int WEIGHT_BITS = bir_pkg::DEF_WEIGHT_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // plane[1:0], row[11:2], col[21:12], sample[37:22], zero fill
    input  logic [bir_pkg::DATA_W-1:0]      s_axis_tdata,
    // cmd
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel[15:0], out_plane[17:16], out_row[27:18], out_col[37:28], zero fill
    output logic [bir_pkg::DATA_W-1:0]      m_axis_tdata,
    // range_error
    output logic                            m_axis_tuser,

    input  logic                            i_cfg_we,
    input  logic [bir_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bir_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import bir_pkg::*;

    // Configuration registers
    logic [SIZE_W-1:0]   r_in_width;
    logic [SIZE_W-1:0]   r_in_height;
    logic [COUNT_W-1:0]  r_channel_count;
    logic [STEP_W-1:0]   r_col_step;
    logic [STEP_W-1:0]   r_row_step;

    // Pipeline control
    logic                w_en;
    logic                w_accept;
    logic [PLANE_W-1:0]  w_plane;
    logic [COORD_W-1:0]  w_row;
    logic [COORD_W-1:0]  w_col;
    logic [SAMPLE_W-1:0] w_sample;
    t_item               n_it1;

    logic                r_v1, r_v2, r_v3, r_v4, r_v5;
    t_item               r_it1, r_it2, r_it3, r_it4, r_it5;
    logic [SAMPLE_W-1:0] r_sample1;
    logic [SAMPLE_W-1:0] r_sample2;

    t_span                  w_xspan;
    t_span                  w_yspan;
    logic [WEIGHT_BITS-1:0] w_wx;
    logic [WEIGHT_BITS-1:0] w_wy;
    t_wr                    w_wr;
    t_quad                  w_quad;
    logic [SAMPLE_W-1:0]    w_pixel;

    // Output and skid registers
    logic                r_out_v;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_user;
    logic                r_skid_v;
    logic [DATA_W-1:0]   r_skid_data;
    logic                r_skid_user;
    logic                w_push;
    logic                w_take;
    logic [DATA_W-1:0]   n_data;
    logic                n_user;

    // Unpack the input word
    assign w_plane  = s_axis_tdata[PLANE_W-1:0];
    assign w_row    = s_axis_tdata[PLANE_W +: COORD_W];
    assign w_col    = s_axis_tdata[PLANE_W+COORD_W +: COORD_W];
    assign w_sample = s_axis_tdata[PLANE_W+2*COORD_W +: SAMPLE_W];

    // The pipeline moves as long as the skid register is free
    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;

    // Classify the word: range error for a resize, store bounds for a load
    always_comb begin
        n_it1.cmd   = s_axis_tuser;
        n_it1.plane = w_plane;
        n_it1.row   = w_row;
        n_it1.col   = w_col;
        if (s_axis_tuser == CMD_RESIZE) begin
            n_it1.flag = ((COUNT_W)'(w_plane) >= r_channel_count)
                      || (5'(w_plane) >= 5'(MAX_PLANES));
        end else begin
            n_it1.flag = (5'(w_plane) < 5'(MAX_PLANES))
                      && ((COORD_W+1)'(w_row) < (COORD_W+1)'(MAX_HEIGHT))
                      && ((COORD_W+1)'(w_col) < (COORD_W+1)'(MAX_WIDTH));
        end
    end

    // Configuration writes and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width      <= RST_IN_WIDTH;
            r_in_height     <= RST_IN_HEIGHT;
            r_channel_count <= RST_CHANNEL_COUNT;
            r_col_step      <= RST_COL_STEP;
            r_row_step      <= RST_ROW_STEP;
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_v3            <= 1'b0;
            r_v4            <= 1'b0;
            r_v5            <= 1'b0;
            r_out_v         <= 1'b0;
            r_skid_v        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_IN_WIDTH:      r_in_width      <= i_cfg_wdata[SIZE_W-1:0];
                    REG_IN_HEIGHT:     r_in_height     <= i_cfg_wdata[SIZE_W-1:0];
                    REG_CHANNEL_COUNT: r_channel_count <= i_cfg_wdata[COUNT_W-1:0];
                    REG_COL_STEP:      r_col_step      <= i_cfg_wdata[STEP_W-1:0];
                    REG_ROW_STEP:      r_row_step      <= i_cfg_wdata[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_en) begin
                r_v1 <= w_accept;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
            end
            if (w_take) begin
                r_out_v  <= r_skid_v || w_push;
                r_skid_v <= 1'b0;
            end else if (w_push) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    // Advance the item bookkeeping alongside the valid bits
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it1     <= n_it1;
            r_sample1 <= w_sample;
            r_it2     <= r_it1;
            r_sample2 <= r_sample1;
            r_it3     <= r_it2;
            r_it4     <= r_it3;
            r_it5     <= r_it4;
        end
    end

    bir_axis #(
        .MAX_SIZE    (MAX_WIDTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_coord  (w_col),
        .i_step   (r_col_step),
        .i_size   (r_in_width),
        .o_span   (w_xspan),
        .o_weight (w_wx)
    );

    bir_axis #(
        .MAX_SIZE    (MAX_HEIGHT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_coord  (w_row),
        .i_step   (r_row_step),
        .i_size   (r_in_height),
        .o_span   (w_yspan),
        .o_weight (w_wy)
    );

    // Store writes happen at the read stage, so loads and reads stay in order
    always_comb begin
        w_wr.we     = r_v2 && (r_it2.cmd == CMD_LOAD) && r_it2.flag;
        w_wr.plane  = r_it2.plane;
        w_wr.row    = r_it2.row;
        w_wr.col    = r_it2.col;
        w_wr.sample = r_sample2;
    end

    bir_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PLANES (MAX_PLANES)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_wr    (w_wr),
        .i_plane (r_it2.plane),
        .i_yspan (w_yspan),
        .i_xspan (w_xspan),
        .o_quad  (w_quad)
    );

    bir_blend #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_wx    (w_wx),
        .i_wy    (w_wy),
        .i_quad  (w_quad),
        .o_pixel (w_pixel)
    );

    // Build the result word; a range error forces the pixel to zero
    assign w_push = w_en && r_v5 && (r_it5.cmd == CMD_RESIZE);
    assign w_take = !r_out_v || m_axis_tready;
    assign n_data = {2'b00, r_it5.col, r_it5.row, r_it5.plane,
                     r_it5.flag ? SAMPLE_W'(0) : w_pixel};
    assign n_user = r_it5.flag;

    // Output register with skid
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_v) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else begin
                r_out_data <= n_data;
                r_out_user <= n_user;
            end
        end else if (w_push) begin
            r_skid_data <= n_data;
            r_skid_user <= n_user;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== hdl/bir_check.sv =====
// ----------------------------------------------------------------------------
// bir_check
// Port-level checks of the resize block: output hold under stall, zero
// pixel on range error, reset behavior and input backpressure cause.
// ----------------------------------------------------------------------------
module bir_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [bir_pkg::DATA_W-1:0]  m_axis_tdata,
    input logic                        m_axis_tuser
);
    import bir_pkg::*;

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // A range error always carries a zero pixel
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[SAMPLE_W-1:0] == '0)
        else $error("range error with nonzero pixel");

    // Drop the output and keep the input ready after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input blocked right after reset");

    // Backpressure only follows a stalled output
    a_bp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
        else $error("input blocked without a stalled output");

endmodule

bind bilinear_image_resize bir_check u_bir_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
